>>> design/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Each macro reports a failure through $error only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge of the given clock outside reset.
`define CHK_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");

// Checks that a condition is never seen at a rising edge outside reset.
`define CHK_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> design/jst_pkg.sv
// Package of the JSON stream tokenizer: parse modes, event codes, characters and helpers.
// Used by every module of the tokenizer but jst_ram, and by its checker.
package jst_pkg;

  // Default limits.
  localparam int MAX_DEPTH_DEF = 16;
  localparam int MAX_ITEMS_DEF = 256;
  localparam int MAX_PAIRS_DEF = 128;

  // Results per input transfer and depth of the result queue.
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 8;

  // Input kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Container kinds on the nesting stack.
  localparam logic K_ARR = 1'b0;
  localparam logic K_OBJ = 1'b1;

  // Event codes.
  localparam logic [3:0] EV_OBJ_BEGIN = 4'd0;
  localparam logic [3:0] EV_OBJ_END   = 4'd1;
  localparam logic [3:0] EV_ARR_BEGIN = 4'd2;
  localparam logic [3:0] EV_ARR_END   = 4'd3;
  localparam logic [3:0] EV_KEY_CHAR  = 4'd4;
  localparam logic [3:0] EV_KEY_END   = 4'd5;
  localparam logic [3:0] EV_STR_CHAR  = 4'd6;
  localparam logic [3:0] EV_STR_END   = 4'd7;
  localparam logic [3:0] EV_NUMBER    = 4'd8;
  localparam logic [3:0] EV_BOOL      = 4'd9;
  localparam logic [3:0] EV_NULL      = 4'd10;
  localparam logic [3:0] EV_COMPLETE  = 4'd11;
  localparam logic [3:0] EV_ERROR     = 4'd12;
  localparam logic [3:0] EV_FINISH    = 4'd13;

  // Document status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  // Characters of the grammar.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_R   = 8'h72;

  // Positions in the literal text "truefalsenull".
  localparam logic [3:0] LIT_TRUE    = 4'd1;
  localparam logic [3:0] LIT_FALSE   = 4'd5;
  localparam logic [3:0] LIT_NULL    = 4'd10;
  localparam logic [3:0] LIT_TRUE_OK = 4'd4;
  localparam logic [3:0] LIT_FALSEOK = 4'd9;
  localparam logic [3:0] LIT_END     = 4'd13;

  // Parse modes, one-hot.
  typedef enum logic [15:0] {
    M_VALUE     = 16'h0001,
    M_FIRST_ARR = 16'h0002,
    M_FIRST_OBJ = 16'h0004,
    M_KEY       = 16'h0008,
    M_COLON     = 16'h0010,
    M_STR       = 16'h0020,
    M_ESC       = 16'h0040,
    M_NUM_SIGN  = 16'h0080,
    M_NUM_INT   = 16'h0100,
    M_NUM_FRAC  = 16'h0200,
    M_NUM_EXPS  = 16'h0400,
    M_NUM_EXP   = 16'h0800,
    M_LIT       = 16'h1000,
    M_AFTER     = 16'h2000,
    M_DONE      = 16'h4000,
    M_ERROR     = 16'h8000
  } mode_t;

  // Whitespace between tokens.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Character of the literal text at a given position.
  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h74;
      4'd1:    r = 8'h72;
      4'd2:    r = 8'h75;
      4'd3:    r = 8'h65;
      4'd4:    r = 8'h66;
      4'd5:    r = 8'h61;
      4'd6:    r = 8'h6C;
      4'd7:    r = 8'h73;
      4'd8:    r = 8'h65;
      4'd9:    r = 8'h6E;
      4'd10:   r = 8'h75;
      4'd11:   r = 8'h6C;
      4'd12:   r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Decoding of an escaped character.
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LO_B: r = 8'h08;
      CH_LO_F: r = 8'h0C;
      CH_LO_N: r = 8'h0A;
      CH_LO_R: r = 8'h0D;
      CH_LO_T: r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

>>> design/jst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module jst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/jst_core.sv
// Parsing core of the JSON stream tokenizer: parse state, top-of-stack registers and the
// nesting stack RAM below them. Depends on jst_pkg and jst_ram.
module jst_core #(
  parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF,
  parameter int MAX_ITEMS = jst_pkg::MAX_ITEMS_DEF,
  parameter int MAX_PAIRS = jst_pkg::MAX_PAIRS_DEF,
  localparam int DEP_W = $clog2(MAX_DEPTH + 1),
  localparam int RES_W = 4 + 64 + DEP_W + 2 + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 kind,
  input  logic [7:0]                           byte_in,
  output logic [jst_pkg::MAX_RES-1:0][RES_W-1:0] lanes,
  output logic [1:0]                           res_n
);

  localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int MAXC  = (MAX_ITEMS > MAX_PAIRS) ? MAX_ITEMS : MAX_PAIRS;
  localparam int CNT_W = $clog2(MAXC + 1);
  localparam int ENT_W = 1 + CNT_W;

  // Parse state registers.
  jst_pkg::mode_t   mode, mode_next;
  logic [DEP_W-1:0] nest, nest_next;
  logic             top_kind, top_kind_next;
  logic [CNT_W-1:0] top_cnt, top_cnt_next;
  logic [63:0]      accum, accum_next;
  logic             neg, neg_next;
  logic [3:0]       lit, lit_next;
  logic             is_key, is_key_next;
  logic [1:0]       status, status_next;

  // Stack RAM and forwarding of a write to the entry being read.
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata, fwd_data, sec;
  logic             fwd;

  logic [3:0][RES_W-1:0] lane;
  logic [1:0]            n;

  function automatic logic [RES_W-1:0] res_pack(input logic [3:0] ev, input logic [63:0] val,
                                                 input logic [DEP_W-1:0] dep,
                                                 input logic [1:0] st);
    return {ev, val, dep, st, 1'b0};
  endfunction

  // Container kind of an opening bracket.
  function automatic logic K_SEL(input logic [7:0] ch);
    return (ch == jst_pkg::CH_LBRACE) ? jst_pkg::K_OBJ : jst_pkg::K_ARR;
  endfunction

  jst_ram #(.WIDTH(ENT_W), .DEPTH(MAX_DEPTH)) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // The entry just below the top of the stack.
  assign sec = fwd ? fwd_data : rdata;

  // Next-state and result logic for one transfer.
  always_comb begin
    logic [7:0]       c;
    logic             do_start, do_after, do_close, k, old_kind;
    logic [DEP_W-1:0] rd_dep;
    logic [63:0]      numval;
    c        = byte_in;
    do_start = 1'b0;
    do_after = 1'b0;
    do_close = 1'b0;
    k        = K_SEL(c);
    old_kind = 1'b0;
    mode_next     = mode;
    nest_next     = nest;
    top_kind_next = top_kind;
    top_cnt_next  = top_cnt;
    accum_next    = accum;
    neg_next      = neg;
    lit_next      = lit;
    is_key_next   = is_key;
    status_next   = status;
    we    = 1'b0;
    waddr = '0;
    wdata = {top_kind, top_cnt};
    lane  = '0;
    n     = 2'd0;
    numval = neg ? (64'd0 - accum) : accum;

    if (kind == jst_pkg::KIND_END) begin
      // End of document: flush a pending number, close out and report the status.
      if (mode == jst_pkg::M_NUM_INT || mode == jst_pkg::M_NUM_FRAC ||
          mode == jst_pkg::M_NUM_EXPS || mode == jst_pkg::M_NUM_EXP) begin
        lane[n] = res_pack(jst_pkg::EV_NUMBER, numval, nest, status_next);
        n = n + 2'd1;
        if (nest == '0) begin
          lane[n] = res_pack(jst_pkg::EV_COMPLETE, '0, '0, status_next);
          n = n + 2'd1;
        end else begin
          status_next = jst_pkg::ST_INVALID;
          lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest, status_next);
          n = n + 2'd1;
        end
      end else if (mode != jst_pkg::M_DONE && mode != jst_pkg::M_ERROR) begin
        status_next = jst_pkg::ST_INVALID;
        lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest, status_next);
        n = n + 2'd1;
      end
      lane[n] = res_pack(jst_pkg::EV_FINISH, '0, nest, status_next);
      n = n + 2'd1;
      mode_next   = jst_pkg::M_VALUE;
      nest_next   = '0;
      accum_next  = '0;
      neg_next    = 1'b0;
      lit_next    = '0;
      is_key_next = 1'b0;
      status_next = jst_pkg::ST_OK;
    end else begin
      unique case (mode)
        jst_pkg::M_VALUE: begin
          if (!jst_pkg::is_ws(c)) begin
            do_start = 1'b1;
          end
        end
        jst_pkg::M_FIRST_ARR: begin
          if (jst_pkg::is_ws(c)) begin
          end else if (c == jst_pkg::CH_RBRACK) begin
            do_close = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
        jst_pkg::M_FIRST_OBJ, jst_pkg::M_KEY: begin
          if (jst_pkg::is_ws(c)) begin
          end else if (mode == jst_pkg::M_FIRST_OBJ && c == jst_pkg::CH_RBRACE) begin
            do_close = 1'b1;
          end else if (c == jst_pkg::CH_QUOTE) begin
            is_key_next = 1'b1;
            mode_next   = jst_pkg::M_STR;
          end else begin
            status_next = jst_pkg::ST_INVALID;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end
        end
        jst_pkg::M_COLON: begin
          if (jst_pkg::is_ws(c)) begin
          end else if (c == jst_pkg::CH_COLON) begin
            mode_next = jst_pkg::M_VALUE;
          end else begin
            status_next = jst_pkg::ST_INVALID;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end
        end
        jst_pkg::M_STR: begin
          if (c == jst_pkg::CH_BSLASH) begin
            mode_next = jst_pkg::M_ESC;
          end else if (c == jst_pkg::CH_QUOTE) begin
            lane[n] = res_pack(is_key ? jst_pkg::EV_KEY_END : jst_pkg::EV_STR_END, '0,
                               nest_next, status_next);
            n = n + 2'd1;
            if (is_key) begin
              mode_next = jst_pkg::M_COLON;
            end else if (nest_next == '0) begin
              mode_next = jst_pkg::M_DONE;
              lane[n] = res_pack(jst_pkg::EV_COMPLETE, '0, '0, status_next);
              n = n + 2'd1;
            end else begin
              top_cnt_next = top_cnt_next + CNT_W'(1);
              mode_next    = jst_pkg::M_AFTER;
            end
          end else begin
            lane[n] = res_pack(is_key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR,
                               {56'd0, c}, nest_next, status_next);
            n = n + 2'd1;
          end
        end
        jst_pkg::M_ESC: begin
          mode_next = jst_pkg::M_STR;
          lane[n] = res_pack(is_key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR,
                             {56'd0, jst_pkg::unescape(c)}, nest_next, status_next);
          n = n + 2'd1;
        end
        jst_pkg::M_NUM_SIGN: begin
          if (jst_pkg::is_digit(c)) begin
            accum_next = {56'd0, c - jst_pkg::CH_ZERO};
            mode_next  = jst_pkg::M_NUM_INT;
          end else begin
            status_next = jst_pkg::ST_INVALID;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end
        end
        jst_pkg::M_NUM_INT, jst_pkg::M_NUM_FRAC, jst_pkg::M_NUM_EXPS,
        jst_pkg::M_NUM_EXP: begin
          // Number body; the first byte outside it ends the number.
          if (mode == jst_pkg::M_NUM_INT && jst_pkg::is_digit(c)) begin
            accum_next = (accum << 3) + (accum << 1) + {56'd0, c - jst_pkg::CH_ZERO};
          end else if (mode == jst_pkg::M_NUM_INT && c == jst_pkg::CH_DOT) begin
            mode_next = jst_pkg::M_NUM_FRAC;
          end else if ((mode == jst_pkg::M_NUM_FRAC || mode == jst_pkg::M_NUM_EXP) &&
                       jst_pkg::is_digit(c)) begin
          end else if ((mode == jst_pkg::M_NUM_INT || mode == jst_pkg::M_NUM_FRAC) &&
                       (c == jst_pkg::CH_LO_E || c == jst_pkg::CH_UP_E)) begin
            mode_next = jst_pkg::M_NUM_EXPS;
          end else if (mode == jst_pkg::M_NUM_EXPS && (c == jst_pkg::CH_PLUS ||
                       c == jst_pkg::CH_MINUS || jst_pkg::is_digit(c))) begin
            mode_next = jst_pkg::M_NUM_EXP;
          end else begin
            lane[n] = res_pack(jst_pkg::EV_NUMBER, numval, nest_next, status_next);
            n = n + 2'd1;
            if (nest_next == '0) begin
              mode_next = jst_pkg::M_DONE;
              lane[n] = res_pack(jst_pkg::EV_COMPLETE, '0, '0, status_next);
              n = n + 2'd1;
            end else begin
              top_cnt_next = top_cnt_next + CNT_W'(1);
              mode_next    = jst_pkg::M_AFTER;
              do_after     = 1'b1;
            end
          end
        end
        jst_pkg::M_LIT: begin
          if (lit < jst_pkg::LIT_END && c == jst_pkg::lit_char(lit)) begin
            lit_next = lit + 4'd1;
            if (lit_next == jst_pkg::LIT_TRUE_OK || lit_next == jst_pkg::LIT_FALSEOK ||
                lit_next == jst_pkg::LIT_END) begin
              if (lit_next == jst_pkg::LIT_END) begin
                lane[n] = res_pack(jst_pkg::EV_NULL, '0, nest_next, status_next);
              end else begin
                lane[n] = res_pack(jst_pkg::EV_BOOL,
                                   (lit_next == jst_pkg::LIT_TRUE_OK) ? 64'd1 : 64'd0,
                                   nest_next, status_next);
              end
              n = n + 2'd1;
              if (nest_next == '0) begin
                mode_next = jst_pkg::M_DONE;
                lane[n] = res_pack(jst_pkg::EV_COMPLETE, '0, '0, status_next);
                n = n + 2'd1;
              end else begin
                top_cnt_next = top_cnt_next + CNT_W'(1);
                mode_next    = jst_pkg::M_AFTER;
              end
            end
          end else begin
            status_next = jst_pkg::ST_INVALID;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end
        end
        jst_pkg::M_AFTER: begin
          do_after = 1'b1;
        end
        default: begin
        end
      endcase

      // Start of a value.
      if (do_start) begin
        if (c == jst_pkg::CH_QUOTE) begin
          is_key_next = 1'b0;
          mode_next   = jst_pkg::M_STR;
        end else if (c == jst_pkg::CH_LBRACE || c == jst_pkg::CH_LBRACK) begin
          if (nest_next >= DEP_W'(MAX_DEPTH)) begin
            status_next = jst_pkg::ST_NO_ROOM;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end else begin
            lane[n] = res_pack((k == jst_pkg::K_OBJ) ? jst_pkg::EV_OBJ_BEGIN :
                               jst_pkg::EV_ARR_BEGIN, '0, nest_next, status_next);
            n = n + 2'd1;
            // Push: the old top moves into the RAM.
            if (nest_next != '0) begin
              we    = 1'b1;
              waddr = AW'(nest_next - DEP_W'(1));
              wdata = {top_kind_next, top_cnt_next};
            end
            top_kind_next = k;
            top_cnt_next  = '0;
            nest_next     = nest_next + DEP_W'(1);
            mode_next     = (k == jst_pkg::K_OBJ) ? jst_pkg::M_FIRST_OBJ :
                            jst_pkg::M_FIRST_ARR;
          end
        end else if (c == jst_pkg::CH_LO_T || c == jst_pkg::CH_LO_F ||
                     c == jst_pkg::CH_LO_N) begin
          lit_next  = (c == jst_pkg::CH_LO_T) ? jst_pkg::LIT_TRUE :
                      (c == jst_pkg::CH_LO_F) ? jst_pkg::LIT_FALSE : jst_pkg::LIT_NULL;
          mode_next = jst_pkg::M_LIT;
        end else if (c == jst_pkg::CH_MINUS) begin
          neg_next   = 1'b1;
          accum_next = '0;
          mode_next  = jst_pkg::M_NUM_SIGN;
        end else if (jst_pkg::is_digit(c)) begin
          neg_next   = 1'b0;
          accum_next = {56'd0, c - jst_pkg::CH_ZERO};
          mode_next  = jst_pkg::M_NUM_INT;
        end else begin
          status_next = jst_pkg::ST_INVALID;
          mode_next   = jst_pkg::M_ERROR;
          lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
          n = n + 2'd1;
        end
      end

      // Separator or closing bracket after an element.
      if (do_after && !jst_pkg::is_ws(c)) begin
        if (nest_next == '0) begin
          status_next = jst_pkg::ST_INVALID;
          mode_next   = jst_pkg::M_ERROR;
          lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
          n = n + 2'd1;
        end else if (c == jst_pkg::CH_COMMA) begin
          if ((top_kind_next == jst_pkg::K_ARR && top_cnt_next >= CNT_W'(MAX_ITEMS)) ||
              (top_kind_next == jst_pkg::K_OBJ && top_cnt_next >= CNT_W'(MAX_PAIRS))) begin
            status_next = jst_pkg::ST_NO_ROOM;
            mode_next   = jst_pkg::M_ERROR;
            lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
            n = n + 2'd1;
          end else begin
            mode_next = (top_kind_next == jst_pkg::K_ARR) ? jst_pkg::M_VALUE :
                        jst_pkg::M_KEY;
          end
        end else if ((c == jst_pkg::CH_RBRACK && top_kind_next == jst_pkg::K_ARR) ||
                     (c == jst_pkg::CH_RBRACE && top_kind_next == jst_pkg::K_OBJ)) begin
          do_close = 1'b1;
        end else begin
          status_next = jst_pkg::ST_INVALID;
          mode_next   = jst_pkg::M_ERROR;
          lane[n] = res_pack(jst_pkg::EV_ERROR, '0, nest_next, status_next);
          n = n + 2'd1;
        end
      end

      // Close a container: pop the entry below into the top registers.
      if (do_close) begin
        old_kind      = top_kind_next;
        nest_next     = nest_next - DEP_W'(1);
        top_kind_next = sec[ENT_W-1];
        top_cnt_next  = sec[CNT_W-1:0];
        lane[n] = res_pack((old_kind == jst_pkg::K_OBJ) ? jst_pkg::EV_OBJ_END :
                           jst_pkg::EV_ARR_END, '0, nest_next, status_next);
        n = n + 2'd1;
        if (nest_next == '0) begin
          mode_next = jst_pkg::M_DONE;
          lane[n] = res_pack(jst_pkg::EV_COMPLETE, '0, '0, status_next);
          n = n + 2'd1;
        end else begin
          top_cnt_next = top_cnt_next + CNT_W'(1);
          mode_next    = jst_pkg::M_AFTER;
        end
      end
    end

    // Mark the last result of this transfer.
    if (n != 2'd0) begin
      lane[n - 2'd1][0] = 1'b1;
    end

    // Prefetch the entry below the top for the next transfer.
    rd_dep = accept ? nest_next : nest;
    raddr  = AW'(rd_dep - DEP_W'(2));
    we     = we & accept;
  end

  assign lanes = lane[jst_pkg::MAX_RES-1:0];
  assign res_n = accept ? n : 2'd0;

  // State update on an accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= jst_pkg::M_VALUE;
      nest   <= '0;
      accum  <= '0;
      neg    <= 1'b0;
      lit    <= '0;
      is_key <= 1'b0;
      status <= jst_pkg::ST_OK;
      fwd    <= 1'b0;
    end else begin
      fwd <= we && (waddr == raddr);
      if (accept) begin
        mode   <= mode_next;
        nest   <= nest_next;
        accum  <= accum_next;
        neg    <= neg_next;
        lit    <= lit_next;
        is_key <= is_key_next;
        status <= status_next;
      end
    end
  end

  // Top-of-stack payload and forwarded RAM data.
  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    if (accept) begin
      top_kind <= top_kind_next;
      top_cnt  <= top_cnt_next;
    end
  end

endmodule

>>> design/jst_outq.sv
// Result queue of the JSON stream tokenizer: takes up to three results per cycle and
// delivers one per transfer. Depends on jst_pkg.
module jst_outq #(
  parameter int W     = 8,
  parameter int DEPTH = jst_pkg::Q_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [1:0]                           push_n,
  input  logic [jst_pkg::MAX_RES-1:0][W-1:0]   push_data,
  input  logic                                 pop,
  output logic                                 full,
  output logic                                 valid,
  output logic [W-1:0]                         data
);

  localparam int QAW = $clog2(DEPTH);

  logic [W-1:0]   entry [DEPTH];
  logic [QAW-1:0] head, tail;
  logic [QAW:0]   count;

  // Hold back input while a full burst might not fit.
  assign full  = count > (QAW + 1)'(DEPTH - jst_pkg::MAX_RES);
  assign valid = count != '0;
  assign data  = entry[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QAW'(pop && valid);
      tail  <= tail + QAW'(push_n);
      count <= count + (QAW + 1)'(push_n) - (QAW + 1)'(pop && valid);
    end
  end

  // Write the burst into consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < jst_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        entry[tail + QAW'(i)] <= push_data[i];
      end
    end
  end

endmodule

>>> design/json_stream_tokenizer.sv
// JSON stream tokenizer: takes one document byte per transfer and returns token events.
// Depends on jst_pkg, jst_core and jst_outq.
// One byte is taken per cycle while in_stall is low; its results, up to three (none for skipped
// whitespace or ignored bytes), are written into an eight-entry result queue and leave it one
// per output transfer. The input stalls while that queue holds more than five results,
// so the byte rate follows the result rate when bytes produce more than one result each.
// The nesting stack sits in a RAM of MAX_DEPTH entries with the open container kept in
// registers; it needs no clearing after reset.
module json_stream_tokenizer #(
  parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF,
  parameter int MAX_ITEMS = jst_pkg::MAX_ITEMS_DEF,
  parameter int MAX_PAIRS = jst_pkg::MAX_PAIRS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [7:0]                         byte_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         event_res,
  output logic signed [63:0]                 value,
  output logic [$clog2(MAX_DEPTH + 1)-1:0]   depth,
  output logic [1:0]                         status,
  output logic                               last
);

  localparam int DEP_W = $clog2(MAX_DEPTH + 1);
  localparam int RES_W = 4 + 64 + DEP_W + 2 + 1;

  logic                                 accept;
  logic [jst_pkg::MAX_RES-1:0][RES_W-1:0] lanes;
  logic [1:0]                           res_n;
  logic [RES_W-1:0]                     head_res;

  assign accept = in_valid && !in_stall;

  jst_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_PAIRS(MAX_PAIRS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .byte_in(byte_req),
    .lanes  (lanes),
    .res_n  (res_n)
  );

  jst_outq #(.W(RES_W), .DEPTH(jst_pkg::Q_DEPTH)) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (res_n),
    .push_data(lanes),
    .pop      (!out_stall),
    .full     (in_stall),
    .valid    (out_valid),
    .data     (head_res)
  );

  // Unpack the result at the head of the queue.
  assign {event_res, value, depth, status, last} = head_res;

endmodule

>>> design/jst_checker.sv
// Port checker of the JSON stream tokenizer, bound to the top level.
// Depends on jst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jst_checker #(
  parameter int DEP_W = 5
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [3:0]       event_res,
  input logic [DEP_W-1:0] depth,
  input logic [1:0]       status,
  input logic             last
);

  // A stalled result stays offered.
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid)

  // A finish event always closes the burst of its transfer.
  `CHK_ASSERT(a_finish_last, clk, rst,
    (out_valid && event_res == jst_pkg::EV_FINISH) |-> last)

  // An error event always carries a failing status.
  `CHK_NEVER(a_error_status, clk, rst,
    out_valid && event_res == jst_pkg::EV_ERROR && status == jst_pkg::ST_OK)

  // A complete document is reported outside every container.
  `CHK_ASSERT(a_complete_depth, clk, rst,
    (out_valid && event_res == jst_pkg::EV_COMPLETE) |-> depth == '0)

endmodule

bind json_stream_tokenizer jst_checker #(.DEP_W($clog2(MAX_DEPTH + 1))) u_jst_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .event_res(event_res),
  .depth    (depth),
  .status   (status),
  .last     (last)
);

>>> verif/tb_json_stream_tokenizer.sv
// Self-checking testbench of json_stream_tokenizer: byte streams in, token events checked.
// Depends on jst_pkg and the json_stream_tokenizer RTL; needs no files or arguments.
module tb_json_stream_tokenizer;
  import jst_pkg::*;

  localparam int DEPTH_LIM = MAX_DEPTH_DEF;
  localparam int WATCHDOG  = 5000;

  // One token event as the block reports it.
  typedef struct packed {
    logic [3:0]  ev;
    logic [63:0] val;
    logic [4:0]  dep;
    logic [1:0]  st;
    logic        lst;
  } token_t;

  // One row of the directed stimulus; chk asks that the last event of the row be ev.
  typedef struct packed {
    logic       knd;
    logic [7:0] chr;
    logic       chk;
    logic [3:0] ev;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_BYTE;
  logic [7:0]  byte_req = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  event_res;
  logic signed [63:0] value;
  logic [4:0]  depth;
  logic [1:0]  status;
  logic        last;

  json_stream_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .byte_req(byte_req),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res), .value(value),
    .depth(depth), .status(status), .last(last)
  );

  always #4 clk = ~clk;

  // Tokenizer state as predicted.
  mode_t       pmode;
  logic        kind_stk [DEPTH_LIM];
  int          count_stk [DEPTH_LIM];
  int          nest;
  logic [63:0] accum;
  logic        negative;
  int          lit_pos;
  logic        in_key;
  logic [1:0]  doc_st;

  token_t      burst[$];
  token_t      pending[$];
  logic [7:0]  doc[$];

  int idle_in = 0;
  int idle_out = 0;
  int errors = 0;
  int bytes_sent = 0;
  int events_seen = 0;
  int docs = 0;
  int quiet = 0;
  logic in_acc, out_acc;

  task automatic clear_state();
    pmode = M_VALUE;
    for (int i = 0; i < DEPTH_LIM; i++) begin
      kind_stk[i] = K_ARR;
      count_stk[i] = 0;
    end
    nest = 0;
    accum = '0;
    negative = 1'b0;
    lit_pos = 0;
    in_key = 1'b0;
    doc_st = ST_OK;
  endtask

  task automatic emit(input logic [3:0] ev, input logic [63:0] val, input int dep);
    if (burst.size() < MAX_RES) burst.push_back('{ev, val, dep[4:0], doc_st, 1'b0});
  endtask

  task automatic fail(input logic [1:0] code);
    doc_st = code;
    pmode = M_ERROR;
    emit(EV_ERROR, '0, nest);
  endtask

  task automatic value_done();
    if (nest == 0) begin
      pmode = M_DONE;
      emit(EV_COMPLETE, '0, 0);
    end else begin
      count_stk[nest-1]++;
      pmode = M_AFTER;
    end
  endtask

  task automatic open_container(input logic [7:0] c);
    logic k;
    k = (c == CH_LBRACE) ? K_OBJ : K_ARR;
    if (nest >= DEPTH_LIM) begin
      fail(ST_NO_ROOM);
    end else begin
      emit(k == K_OBJ ? EV_OBJ_BEGIN : EV_ARR_BEGIN, '0, nest);
      kind_stk[nest] = k;
      count_stk[nest] = 0;
      nest++;
      pmode = (k == K_OBJ) ? M_FIRST_OBJ : M_FIRST_ARR;
    end
  endtask

  task automatic close_container();
    logic k;
    k = kind_stk[nest-1];
    nest--;
    emit(k == K_OBJ ? EV_OBJ_END : EV_ARR_END, '0, nest);
    value_done();
  endtask

  task automatic start_value(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      in_key = 1'b0;
      pmode = M_STR;
    end else if (c == CH_LBRACE || c == CH_LBRACK) begin
      open_container(c);
    end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
      lit_pos = (c == CH_LO_T) ? LIT_TRUE : (c == CH_LO_F) ? LIT_FALSE : LIT_NULL;
      pmode = M_LIT;
    end else if (c == CH_MINUS) begin
      negative = 1'b1;
      accum = '0;
      pmode = M_NUM_SIGN;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      negative = 1'b0;
      accum = 64'(c - CH_ZERO);
      pmode = M_NUM_INT;
    end else begin
      fail(ST_INVALID);
    end
  endtask

  task automatic after_value(input logic [7:0] c);
    logic k;
    int cnt;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
    if (nest == 0) begin
      fail(ST_INVALID);
      return;
    end
    k = kind_stk[nest-1];
    cnt = count_stk[nest-1];
    if (c == CH_COMMA) begin
      if (k == K_ARR && cnt >= MAX_ITEMS_DEF) fail(ST_NO_ROOM);
      else if (k == K_OBJ && cnt >= MAX_PAIRS_DEF) fail(ST_NO_ROOM);
      else pmode = (k == K_ARR) ? M_VALUE : M_KEY;
    end else if ((c == CH_RBRACK && k == K_ARR) || (c == CH_RBRACE && k == K_OBJ)) begin
      close_container();
    end else begin
      fail(ST_INVALID);
    end
  endtask

  function automatic logic [63:0] signed_accum();
    return negative ? 64'd0 - accum : accum;
  endfunction

  task automatic end_number(input logic [7:0] c);
    emit(EV_NUMBER, signed_accum(), nest);
    value_done();
    if (pmode == M_AFTER) after_value(c);
  endtask

  function automatic logic [7:0] lit_text(input int i);
    string s;
    s = "truefalsenull";
    return s[i];
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    case (c)
      CH_LO_B: return 8'h08;
      CH_LO_F: return 8'h0C;
      CH_LO_N: return 8'h0A;
      CH_LO_R: return 8'h0D;
      CH_LO_T: return 8'h09;
      default: return c;
    endcase
  endfunction

  // Works out the events of one document byte.
  task automatic tokenize_byte(input logic [7:0] c);
    logic ws, dig;
    ws = (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR);
    dig = (c >= CH_ZERO && c <= CH_NINE);
    case (pmode)
      M_VALUE: if (!ws) start_value(c);
      M_FIRST_ARR: begin
        if (ws) ;
        else if (c == CH_RBRACK) close_container();
        else start_value(c);
      end
      M_FIRST_OBJ, M_KEY: begin
        if (ws) ;
        else if (pmode == M_FIRST_OBJ && c == CH_RBRACE) close_container();
        else if (c == CH_QUOTE) begin
          in_key = 1'b1;
          pmode = M_STR;
        end else fail(ST_INVALID);
      end
      M_COLON: begin
        if (ws) ;
        else if (c == CH_COLON) pmode = M_VALUE;
        else fail(ST_INVALID);
      end
      M_STR: begin
        if (c == CH_BSLASH) pmode = M_ESC;
        else if (c == CH_QUOTE) begin
          emit(in_key ? EV_KEY_END : EV_STR_END, '0, nest);
          if (in_key) pmode = M_COLON;
          else value_done();
        end else emit(in_key ? EV_KEY_CHAR : EV_STR_CHAR, 64'(c), nest);
      end
      M_ESC: begin
        pmode = M_STR;
        emit(in_key ? EV_KEY_CHAR : EV_STR_CHAR, 64'(decode_escape(c)), nest);
      end
      M_NUM_SIGN: begin
        if (dig) begin
          accum = 64'(c - CH_ZERO);
          pmode = M_NUM_INT;
        end else fail(ST_INVALID);
      end
      M_NUM_INT: begin
        if (dig) accum = accum * 64'd10 + 64'(c - CH_ZERO);
        else if (c == CH_DOT) pmode = M_NUM_FRAC;
        else if (c == CH_LO_E || c == CH_UP_E) pmode = M_NUM_EXPS;
        else end_number(c);
      end
      M_NUM_FRAC: begin
        if (dig) ;
        else if (c == CH_LO_E || c == CH_UP_E) pmode = M_NUM_EXPS;
        else end_number(c);
      end
      M_NUM_EXPS: begin
        if (c == CH_PLUS || c == CH_MINUS || dig) pmode = M_NUM_EXP;
        else end_number(c);
      end
      M_NUM_EXP: if (!dig) end_number(c);
      M_LIT: begin
        if (lit_pos < LIT_END && c == lit_text(lit_pos)) begin
          lit_pos++;
          if (lit_pos == LIT_TRUE_OK || lit_pos == LIT_FALSEOK) begin
            emit(EV_BOOL, (lit_pos == LIT_TRUE_OK) ? 64'd1 : 64'd0, nest);
            value_done();
          end else if (lit_pos == LIT_END) begin
            emit(EV_NULL, '0, nest);
            value_done();
          end
        end else fail(ST_INVALID);
      end
      M_AFTER: after_value(c);
      default: ;
    endcase
  endtask

  // Works out the events of one accepted transfer and queues them.
  task automatic predict_transfer(input logic k, input logic [7:0] c);
    burst.delete();
    if (k == KIND_BYTE) begin
      tokenize_byte(c);
    end else begin
      if (pmode inside {M_NUM_INT, M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXP}) begin
        emit(EV_NUMBER, signed_accum(), nest);
        if (nest == 0) emit(EV_COMPLETE, '0, 0);
        else fail(ST_INVALID);
      end else if (pmode != M_DONE && pmode != M_ERROR) begin
        fail(ST_INVALID);
      end
      emit(EV_FINISH, '0, nest);
      clear_state();
    end
    if (burst.size() > 0) burst[burst.size()-1].lst = 1'b1;
    foreach (burst[i]) pending.push_back(burst[i]);
  endtask

  // Offers one transfer and waits until the block takes it.
  task automatic send(input logic k, input logic [7:0] c);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    byte_req <= c;
    do @(posedge clk); while (in_stall);
    predict_transfer(k, c);
    bytes_sent++;
  endtask

  // Receiver: random stall, and every result compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      events_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected event %0d value %0d", $time, event_res, value);
        errors++;
      end else begin
        token_t e;
        e = pending.pop_front();
        if (e.ev != event_res || e.val != value || e.dep != depth || e.st != status ||
            e.lst != last) begin
          $display("%0t: mismatch expected ev %0d val %0d dep %0d st %0d last %0b",
                   $time, e.ev, $signed(e.val), e.dep, e.st, e.lst);
          $display("%0t:          actual   ev %0d val %0d dep %0d st %0d last %0b",
                   $time, event_res, value, depth, status, last);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_out);
  end

  // Watchdog on cycles in which nothing is accepted.
  always @(posedge clk) begin
    in_acc = in_valid && !in_stall;
    out_acc = out_valid && !out_stall;
    if (rst || in_acc || out_acc) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Watchdog expired with %0d events outstanding", pending.size());
      $display("FAIL");
      $finish;
    end
  end

  // Document generators.
  task automatic put(input string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endtask

  task automatic put_ws();
    logic [7:0] wsc [4];
    wsc = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    if ($urandom_range(3) == 0) doc.push_back(wsc[$urandom_range(3)]);
  endtask

  task automatic put_string();
    logic [7:0] c;
    doc.push_back(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(4) == 0) begin
        doc.push_back(CH_BSLASH);
        doc.push_back(8'($urandom_range(255)));
      end else begin
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
        doc.push_back(c);
      end
    end
    doc.push_back(CH_QUOTE);
  endtask

  task automatic put_number();
    if ($urandom_range(1)) doc.push_back(CH_MINUS);
    repeat ($urandom_range(1, $urandom_range(3) == 0 ? 22 : 4))
      doc.push_back(8'(CH_ZERO + $urandom_range(9)));
    if ($urandom_range(2) == 0) begin
      doc.push_back(CH_DOT);
      repeat ($urandom_range(3)) doc.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
    if ($urandom_range(2) == 0) begin
      doc.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
      case ($urandom_range(2))
        0: doc.push_back(CH_PLUS);
        1: doc.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(2)) doc.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic put_value(input int lvl);
    int n;
    case ($urandom_range(0, lvl > 3 ? 2 : 4))
      0: put_number();
      1: put_string();
      2: case ($urandom_range(2))
           0: put("true");
           1: put("false");
           default: put("null");
         endcase
      3: begin
        doc.push_back(CH_LBRACK);
        put_ws();
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(CH_COMMA);
          put_ws();
          put_value(lvl + 1);
          put_ws();
        end
        doc.push_back(CH_RBRACK);
      end
      default: begin
        doc.push_back(CH_LBRACE);
        put_ws();
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(CH_COMMA);
          put_ws();
          put_string();
          put_ws();
          doc.push_back(CH_COLON);
          put_ws();
          put_value(lvl + 1);
          put_ws();
        end
        doc.push_back(CH_RBRACE);
      end
    endcase
  endtask

  // Sends the document held in doc, then the end marker.
  task automatic send_doc();
    foreach (doc[i]) send(KIND_BYTE, doc[i]);
    send(KIND_END, 8'($urandom_range(255)));
    doc.delete();
    docs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Directed rows: end before any byte, a number with fraction and exponent, an escape,
  // a literal, trailing bytes after completion, and a lone minus.
  row_t rows [24] = '{
    '{KIND_END,  8'h00,     1'b1, EV_FINISH},
    '{KIND_BYTE, CH_LBRACK, 1'b1, EV_ARR_BEGIN},
    '{KIND_BYTE, CH_MINUS,  1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_NINE,   1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_DOT,    1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_LO_E,   1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_MINUS,  1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, 8'h31,     1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_COMMA,  1'b1, EV_NUMBER},
    '{KIND_BYTE, CH_QUOTE,  1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_BSLASH, 1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_LO_N,   1'b1, EV_STR_CHAR},
    '{KIND_BYTE, CH_QUOTE,  1'b1, EV_STR_END},
    '{KIND_BYTE, CH_COMMA,  1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_LO_T,   1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_LO_R,   1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, 8'h75,     1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, CH_LO_E,   1'b1, EV_BOOL},
    '{KIND_BYTE, CH_RBRACK, 1'b1, EV_COMPLETE},
    '{KIND_BYTE, 8'hFF,     1'b0, EV_OBJ_BEGIN},
    '{KIND_END,  8'hFF,     1'b1, EV_FINISH},
    '{KIND_BYTE, CH_MINUS,  1'b0, EV_OBJ_BEGIN},
    '{KIND_BYTE, 8'h78,     1'b1, EV_ERROR},
    '{KIND_END,  8'h00,     1'b1, EV_FINISH}
  };

  initial begin
    int target;
    clear_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the quick typed checks where a row asks for one.
    idle_in = 36;
    idle_out = 65;
    foreach (rows[i]) begin
      send(rows[i].knd, rows[i].chr);
      if (rows[i].chk && (burst.size() == 0 || burst[burst.size()-1].ev != rows[i].ev)) begin
        $display("%0t: row %0d expected last event %0d", $time, i, rows[i].ev);
        errors++;
      end
    end

    // Sender pauses until every outstanding event has come back.
    drain();

    // Random documents in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      idle_in = (ph == 0) ? 36 : (ph == 1) ? 65 : 0;
      idle_out = (ph == 0) ? 65 : (ph == 1) ? 36 : 0;
      target = bytes_sent + 55;
      while (bytes_sent < target) begin
        case ($urandom_range(19))
          0: repeat ($urandom_range(1, 12)) doc.push_back(8'($urandom_range(255)));
          1, 2: begin
            put_value(0);
            if (doc.size() > 1) doc.delete($urandom_range(doc.size() - 1));
            doc.push_back(8'($urandom_range(255)));
          end
          3: begin
            put_value(0);
            repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(255)));
          end
          4: put_number();
          default: begin
            put_ws();
            put_value($urandom_range(1));
            put_ws();
          end
        endcase
        send_doc();
      end
      // Nesting too deep: an array opened, an object opened, or an array opened as the
      // value of a key, each at the full depth.
      case (ph)
        0: repeat (DEPTH_LIM + 1) doc.push_back(CH_LBRACK);
        1: begin
          repeat (DEPTH_LIM) doc.push_back(CH_LBRACK);
          doc.push_back(CH_LBRACE);
        end
        default: begin
          repeat (DEPTH_LIM - 1) doc.push_back(CH_LBRACK);
          put("{\"\":[");
        end
      endcase
      send_doc();
    end

    drain();
    $display("Sent %0d transfers in %0d documents; checked %0d token events.",
             bytes_sent, docs, events_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
